// ----- src/image_tuning_control_smoother_assert.svh -----
// assertion macros for the image tuning control smoother
`ifndef IMAGE_TUNING_CONTROL_SMOOTHER_ASSERT_SVH
`define IMAGE_TUNING_CONTROL_SMOOTHER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, held off during reset
`define ITC_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("image tuning control smoother check failed");

// clocked check that also holds during reset
`define ITC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("image tuning control smoother check failed");

`else

`define ITC_ASSERT_CLK(lbl, clk, rst_n, prop)
`define ITC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- src/itc_pkg.sv -----
// shared types, constants and delta tables for the image tuning control smoother
package itc_pkg;

    localparam int NUM_CTRL  = 5;
    localparam int NUM_TIER  = 4;
    localparam int NUM_TABLE = 3;
    localparam int CTRL_W    = 7;
    localparam int TIER_W    = 2;
    localparam int REQ_W     = 4;
    localparam int MODE_W    = 2;
    localparam int CEIL_W    = 28;
    localparam int IDX_W     = 3;

    typedef logic [CTRL_W-1:0]               t_ctrl;
    typedef logic [NUM_CTRL-1:0][CTRL_W-1:0] t_ctrls;
    typedef logic [TIER_W-1:0]               t_tier;
    typedef logic [MODE_W-1:0]               t_mode;
    typedef logic [IDX_W-1:0]                t_idx;

    typedef struct packed {
        t_ctrls              base;
        t_mode               mode;
        logic [CEIL_W-1:0]   ceilings;
    } t_cfg;

    // control order within t_ctrls
    localparam int CTRL_SAT   = 0;
    localparam int CTRL_SHARP = 1;
    localparam int CTRL_DN2D  = 2;
    localparam int CTRL_DN3D  = 3;
    localparam int CTRL_GAMMA = 4;

    localparam t_mode MODE_QUIET    = 2'd0;
    localparam t_mode MODE_DETAIL   = 2'd1;
    localparam t_mode MODE_STANDARD = 2'd2;

    localparam t_idx REG_BASE_SAT   = 3'd0;
    localparam t_idx REG_BASE_SHARP = 3'd1;
    localparam t_idx REG_BASE_DN2D  = 3'd2;
    localparam t_idx REG_BASE_DN3D  = 3'd3;
    localparam t_idx REG_BASE_GAMMA = 3'd4;
    localparam t_idx REG_MODE       = 3'd5;
    localparam t_idx REG_CEILINGS   = 3'd6;

    localparam t_ctrl CTRL_MAX = 7'd100;

    localparam t_ctrl RST_BASE_SAT   = 7'd52;
    localparam t_ctrl RST_BASE_SHARP = 7'd32;
    localparam t_ctrl RST_BASE_DN2D  = 7'd60;
    localparam t_ctrl RST_BASE_DN3D  = 7'd52;
    localparam t_ctrl RST_BASE_GAMMA = 7'd50;
    localparam logic [CEIL_W-1:0] RST_CEILINGS = 28'd211366500;

    // reciprocal of three, scaled by 2^RECIP3_SH; exact for 7-bit magnitudes
    localparam int RECIP3    = 171;
    localparam int RECIP3_SH = 9;

    // deltas indexed [table][control][tier]
    localparam int DELTA [NUM_TABLE][NUM_CTRL][NUM_TIER] = '{
        '{ // quiet
            '{0, -2, -6, -12},
            '{-2, -4, -10, -16},
            '{4, 10, 18, 26},
            '{4, 12, 26, 36},
            '{0, 1, 4, 7}
        },
        '{ // detail
            '{5, 2, -4, -10},
            '{8, 2, -8, -18},
            '{-6, 2, 12, 24},
            '{-4, 4, 16, 28},
            '{0, 3, 7, 10}
        },
        '{ // standard
            '{0, 0, -6, -14},
            '{0, -6, -14, -24},
            '{0, 8, 18, 30},
            '{0, 10, 22, 34},
            '{0, 2, 5, 8}
        }
    };

    function automatic t_tier clamp_tier(input logic signed [REQ_W-1:0] req);
        t_tier t;
        if (req < 0) begin
            t = '0;
        end else if (req > $signed(REQ_W'(NUM_TIER - 1))) begin
            t = TIER_W'(NUM_TIER - 1);
        end else begin
            t = req[TIER_W-1:0];
        end
        return t;
    endfunction

endpackage

// ----- src/itc_cfg.sv -----
// configuration registers of the image tuning control smoother
module itc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  itc_pkg::t_idx                i_cfg_idx,
    input  logic [itc_pkg::CEIL_W-1:0]   i_cfg_data,
    output itc_pkg::t_cfg                o_cfg
);

    itc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base[itc_pkg::CTRL_SAT]   <= itc_pkg::RST_BASE_SAT;
            r_cfg.base[itc_pkg::CTRL_SHARP] <= itc_pkg::RST_BASE_SHARP;
            r_cfg.base[itc_pkg::CTRL_DN2D]  <= itc_pkg::RST_BASE_DN2D;
            r_cfg.base[itc_pkg::CTRL_DN3D]  <= itc_pkg::RST_BASE_DN3D;
            r_cfg.base[itc_pkg::CTRL_GAMMA] <= itc_pkg::RST_BASE_GAMMA;
            r_cfg.mode                      <= itc_pkg::MODE_QUIET;
            r_cfg.ceilings                  <= itc_pkg::RST_CEILINGS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx) inside
                [itc_pkg::REG_BASE_SAT:itc_pkg::REG_BASE_GAMMA]: begin
                    r_cfg.base[i_cfg_idx] <= i_cfg_data[itc_pkg::CTRL_W-1:0];
                end
                itc_pkg::REG_MODE: begin
                    r_cfg.mode <= i_cfg_data[itc_pkg::MODE_W-1:0];
                end
                itc_pkg::REG_CEILINGS: begin
                    r_cfg.ceilings <= i_cfg_data;
                end
                default: begin
                    // index beyond the register list, ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/itc_calc.sv -----
// target, smoothing and cap arithmetic for one item
module itc_calc (
    input  itc_pkg::t_cfg   i_cfg,
    input  itc_pkg::t_tier  i_tier,
    input  logic            i_active,
    input  itc_pkg::t_ctrls i_held,
    output itc_pkg::t_ctrls o_ctrls,
    output itc_pkg::t_ctrl  o_ceiling,
    output logic            o_quiet_mode
);

    itc_pkg::t_mode tbl;
    itc_pkg::t_ctrl ceiling;
    logic           quiet_mode;

    assign quiet_mode = (i_cfg.mode == itc_pkg::MODE_QUIET);
    // unused mode code falls back to the standard table
    assign tbl = (i_cfg.mode > itc_pkg::MODE_STANDARD) ? itc_pkg::MODE_STANDARD : i_cfg.mode;
    assign ceiling = i_cfg.ceilings[itc_pkg::CTRL_W*i_tier +: itc_pkg::CTRL_W];

    always_comb begin
        logic signed [8:0]  sum     [itc_pkg::NUM_CTRL];
        itc_pkg::t_ctrl     target  [itc_pkg::NUM_CTRL];
        logic signed [7:0]  diff    [itc_pkg::NUM_CTRL];
        itc_pkg::t_ctrl     mag     [itc_pkg::NUM_CTRL];
        logic [15:0]        prod    [itc_pkg::NUM_CTRL];
        itc_pkg::t_ctrl     quot    [itc_pkg::NUM_CTRL];
        itc_pkg::t_ctrl     res     [itc_pkg::NUM_CTRL];
        for (int i = 0; i < itc_pkg::NUM_CTRL; i++) begin
            sum[i] = $signed({2'b00, i_cfg.base[i]})
                   + 9'(itc_pkg::DELTA[tbl][i][i_tier]);
            if (sum[i] < 0) begin
                target[i] = '0;
            end else if (sum[i] > $signed({2'b00, itc_pkg::CTRL_MAX})) begin
                target[i] = itc_pkg::CTRL_MAX;
            end else begin
                target[i] = sum[i][itc_pkg::CTRL_W-1:0];
            end
            if (i == itc_pkg::CTRL_DN3D && quiet_mode && target[i] > ceiling) begin
                target[i] = ceiling;
            end

            // one third of the way, truncated toward zero
            diff[i] = $signed({1'b0, target[i]}) - $signed({1'b0, i_held[i]});
            mag[i]  = (diff[i] < 0) ? 7'(-diff[i]) : diff[i][itc_pkg::CTRL_W-1:0];
            prod[i] = 16'(mag[i]) * 16'(itc_pkg::RECIP3);
            quot[i] = 7'(prod[i] >> itc_pkg::RECIP3_SH);
            if (!i_active) begin
                res[i] = target[i];
            end else if (diff[i] < 0) begin
                res[i] = i_held[i] - quot[i];
            end else begin
                res[i] = i_held[i] + quot[i];
            end

            if (i == itc_pkg::CTRL_DN3D && quiet_mode && res[i] > ceiling) begin
                res[i] = ceiling;
            end
            o_ctrls[i] = res[i];
        end
    end

    assign o_ceiling    = ceiling;
    assign o_quiet_mode = quiet_mode;

endmodule

// ----- src/image_tuning_control_smoother.sv -----
// Image tuning control smoother, top level. Takes one beat per clock cycle
// while not stalled and returns one result beat per input beat: the clamped
// tier is captured in an input register, then the delta lookup, 0..100 clamp,
// one-third smoothing and quiet-mode 3D denoise cap run in a single
// combinational pass into the result register. The result register doubles
// as the held smoothing state, so each item sees the previous item's result
// without a bubble. The input side stalls only while both registers are full
// and the output is stalled. Configuration is five base controls, the mode
// and the packed per-tier 3D denoise ceilings, written through a plain
// index/data write port.
`include "image_tuning_control_smoother_assert.svh"

module image_tuning_control_smoother (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  itc_pkg::t_idx                  i_cfg_idx,
    input  logic [itc_pkg::CEIL_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [itc_pkg::REQ_W-1:0] i_requested_tier,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [itc_pkg::CTRL_W-1:0]     o_out_saturation,
    output logic [itc_pkg::CTRL_W-1:0]     o_out_sharpness,
    output logic [itc_pkg::CTRL_W-1:0]     o_out_denoise_2d,
    output logic [itc_pkg::CTRL_W-1:0]     o_out_denoise_3d,
    output logic [itc_pkg::CTRL_W-1:0]     o_out_gamma,
    output logic [itc_pkg::TIER_W-1:0]     o_applied_tier
);

    itc_pkg::t_cfg   cfg;
    itc_pkg::t_ctrls n_ctrls;
    itc_pkg::t_ctrl  ceiling;
    logic            quiet_mode;
    logic            in_take;
    logic            advance;

    logic            r_in_valid;
    itc_pkg::t_tier  r_tier;
    logic            r_out_valid;
    itc_pkg::t_ctrls r_ctrls;
    itc_pkg::t_tier  r_out_tier;
    logic            r_active;

    itc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    itc_calc u_calc (
        .i_cfg        (cfg),
        .i_tier       (r_tier),
        .i_active     (r_active),
        .i_held       (r_ctrls),
        .o_ctrls      (n_ctrls),
        .o_ceiling    (ceiling),
        .o_quiet_mode (quiet_mode)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_active    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers; result register is also the held smoothing state
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tier <= itc_pkg::clamp_tier(i_requested_tier);
        end
        if (advance) begin
            r_ctrls    <= n_ctrls;
            r_out_tier <= r_tier;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_saturation = r_ctrls[itc_pkg::CTRL_SAT];
    assign o_out_sharpness  = r_ctrls[itc_pkg::CTRL_SHARP];
    assign o_out_denoise_2d = r_ctrls[itc_pkg::CTRL_DN2D];
    assign o_out_denoise_3d = r_ctrls[itc_pkg::CTRL_DN3D];
    assign o_out_gamma      = r_ctrls[itc_pkg::CTRL_GAMMA];
    assign o_applied_tier   = r_out_tier;

    `ITC_ASSERT_CLK(a_active_sticks, i_clk, i_rst_n, r_active |=> r_active)
    `ITC_ASSERT_CLK(a_out_needs_active, i_clk, i_rst_n, o_out_valid |-> r_active)
    `ITC_ASSERT_CLK(a_take_fills_input, i_clk, i_rst_n, in_take |=> r_in_valid)
    `ITC_ASSERT_CLK(a_ctrl_range, i_clk, i_rst_n, o_out_valid |-> (o_out_saturation <= itc_pkg::CTRL_MAX && o_out_sharpness <= itc_pkg::CTRL_MAX && o_out_denoise_2d <= itc_pkg::CTRL_MAX && o_out_denoise_3d <= itc_pkg::CTRL_MAX && o_out_gamma <= itc_pkg::CTRL_MAX))
    `ITC_ASSERT_CLK(a_quiet_cap, i_clk, i_rst_n, (advance && quiet_mode) |=> (o_out_denoise_3d <= $past(ceiling)))

endmodule
